// ===== hdl/palm_pkg.sv =====
// ----------------------------------------------------------------------------
// palm_pkg
// Types and constants shared by the pulse activity and link monitor.
// ----------------------------------------------------------------------------
package palm_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned EVQ_DEPTH  = 8;
    localparam int unsigned EVQ_PTR_W  = $clog2(EVQ_DEPTH);
    localparam int unsigned EVQ_CNT_W  = $clog2(EVQ_DEPTH + 1);

    localparam logic [15:0] JUMP_LIMIT_RST    = 16'd100;
    localparam logic [7:0]  QUIET_TIMEOUT_RST = 8'd15;
    localparam logic [9:0]  LINK_TIMEOUT_RST  = 10'd60;
    localparam logic [15:0] SENSOR_ID_RST     = 16'd0;
    localparam logic [15:0] INIT_COUNT_RST    = 16'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_JUMP_LIMIT    = 3'd0,
        CFG_QUIET_TIMEOUT = 3'd1,
        CFG_LINK_TIMEOUT  = 3'd2,
        CFG_SENSOR_ID     = 3'd3,
        CFG_INIT_COUNT    = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        EV_START     = 3'd0,
        EV_CONTINUE  = 3'd1,
        EV_END       = 3'd2,
        EV_DISCONN   = 3'd3,
        EV_RECONN    = 3'd4
    } t_event_kind;

    typedef struct packed {
        t_event_kind kind;
        logic [31:0] ev_time;
        logic [31:0] open_time;
        logic [31:0] pulse_time;
        logic [15:0] total;
        logic [15:0] base;
        logic [15:0] final_cnt;
        logic        last;
    } t_evt;

endpackage

// ===== hdl/pulse_activity_and_link_monitor.sv =====
// ----------------------------------------------------------------------------
// pulse_activity_and_link_monitor
// Tracks a free-running pulse counter for crossing start, continue and end
// events and watches the link flag for disconnect and reconnect events.
// ----------------------------------------------------------------------------
// A sample is registered on acceptance and evaluated in the next cycle, where
// the crossing and link state update and up to two events are written into an
// eight-entry event queue, from which an event reaches the output. The input
// side takes a sample in any cycle in which the queue keeps at least four free
// slots beyond the two reserved for a sample in flight. The output port moves
// one event per cycle while i_out_stall is low, which sets the sustained rate:
// one sample per cycle when each gives at most one event, less when each gives
// two. The sensor identifier is driven from its configuration register, which
// the user must change only while the block is idle; the block does not enforce it.
module pulse_activity_and_link_monitor
    import palm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [15:0]           i_pulse_count,
    input  logic                  i_link_up,
    input  logic [31:0]           i_now_seconds,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [2:0]            o_event_kind,
    output logic [15:0]           o_event_sensor,
    output logic [31:0]           o_event_time,
    output logic [31:0]           o_crossing_start_time,
    output logic [31:0]           o_crossing_last_time,
    output logic [15:0]           o_pulses_total,
    output logic [15:0]           o_base_count,
    output logic [15:0]           o_final_count,
    output logic                  o_last_of_run
);

    // Configuration.
    logic [15:0] r_jump_limit;
    logic [7:0]  r_quiet_timeout;
    logic [9:0]  r_link_timeout;
    logic [15:0] r_sensor_id;

    // Input register.
    logic        r_in_vld;
    logic [15:0] r_pulse_count;
    logic        r_link_up;
    logic [31:0] r_now;

    // Crossing and link state.
    logic        r_detecting,   n_detecting;
    logic [31:0] r_open_time,   n_open_time;
    logic [31:0] r_act_time,    n_act_time;
    logic [15:0] r_base,        n_base;
    logic [15:0] r_prev,        n_prev;
    logic        r_link_lost,   n_link_lost;
    logic        r_loss_pend,   n_loss_pend;
    logic [31:0] r_loss_since,  n_loss_since;

    // Event queue.
    t_evt                 r_evq [EVQ_DEPTH];
    logic [EVQ_PTR_W-1:0] r_wr_ptr;
    logic [EVQ_PTR_W-1:0] r_rd_ptr;
    logic [EVQ_CNT_W-1:0] r_evq_cnt;

    logic [15:0] step;
    logic        jump;
    logic [15:0] base_eff;
    logic [31:0] start_eff;
    logic [31:0] act_eff;
    logic        det_eff;
    logic [15:0] total;
    logic        quiet_over;
    logic        link_over;
    logic        cr_vld;
    logic        lk_vld;
    t_evt        cr_evt;
    t_evt        lk_evt;
    t_evt        slot0;
    logic [1:0]  push_cnt;
    logic        pop;
    logic [EVQ_CNT_W-1:0] inflight;
    t_evt        head;

    // Room is judged on registered state only: the queue count plus two slots
    // reserved for a sample still sitting in the input register.
    assign inflight   = r_in_vld ? EVQ_CNT_W'(2) : EVQ_CNT_W'(0);
    assign o_in_stall = (r_evq_cnt + inflight) > EVQ_CNT_W'(EVQ_DEPTH - 4);

    always_comb begin
        step      = r_pulse_count - r_prev;
        jump      = step > r_jump_limit;
        // A jump re-bases the counter and drops any crossing in progress.
        base_eff  = jump ? r_pulse_count : r_base;
        start_eff = jump ? 32'd0 : r_open_time;
        act_eff   = jump ? 32'd0 : r_act_time;
        det_eff   = jump ? 1'b0 : r_detecting;
        total     = r_pulse_count - base_eff;
        quiet_over = {1'b0, r_now} > ({1'b0, act_eff} + {25'd0, r_quiet_timeout});
        link_over  = {1'b0, r_now} > ({1'b0, r_loss_since} + {23'd0, r_link_timeout});

        n_detecting  = det_eff;
        n_open_time  = start_eff;
        n_act_time   = act_eff;
        n_base       = base_eff;
        n_prev       = r_pulse_count;
        n_link_lost  = r_link_lost;
        n_loss_pend  = r_loss_pend;
        n_loss_since = r_loss_since;

        cr_vld = 1'b0;
        cr_evt = '0;
        cr_evt.total = total;
        cr_evt.ev_time = r_now;
        if (!det_eff) begin
            if (total != 16'd0) begin
                cr_vld       = 1'b1;
                cr_evt.kind  = EV_START;
                n_open_time  = r_now;
                n_act_time   = r_now;
                n_detecting  = 1'b1;
            end
        end else if (!jump && step != 16'd0) begin
            cr_vld      = 1'b1;
            cr_evt.kind = EV_CONTINUE;
            n_act_time  = r_now;
        end else if (quiet_over) begin
            cr_vld            = 1'b1;
            cr_evt.kind       = EV_END;
            cr_evt.open_time  = start_eff;
            cr_evt.pulse_time = act_eff;
            cr_evt.base       = base_eff;
            cr_evt.final_cnt  = r_pulse_count;
            n_base            = r_pulse_count;
            n_detecting       = 1'b0;
        end

        lk_vld = 1'b0;
        lk_evt = '0;
        lk_evt.kind = EV_RECONN;
        lk_evt.ev_time = r_now;
        lk_evt.last = 1'b1;
        if (r_link_lost) begin
            if (r_link_up) begin
                lk_vld      = 1'b1;
                n_link_lost = 1'b0;
                n_loss_pend = 1'b0;
            end
        end else if (r_loss_pend) begin
            if (link_over) begin
                lk_vld      = 1'b1;
                lk_evt.kind = EV_DISCONN;
                n_link_lost = 1'b1;
            end else if (r_link_up) begin
                n_loss_pend = 1'b0;
            end
        end else if (!r_link_up) begin
            n_loss_pend  = 1'b1;
            n_loss_since = r_now;
        end

        cr_evt.last = !lk_vld;
        slot0       = cr_vld ? cr_evt : lk_evt;
        push_cnt    = r_in_vld ? ({1'b0, cr_vld} + {1'b0, lk_vld}) : 2'd0;
    end

    assign pop  = o_out_valid && !i_out_stall;
    assign head = r_evq[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jump_limit    <= JUMP_LIMIT_RST;
            r_quiet_timeout <= QUIET_TIMEOUT_RST;
            r_link_timeout  <= LINK_TIMEOUT_RST;
            r_sensor_id     <= SENSOR_ID_RST;
            r_in_vld        <= 1'b0;
            r_detecting     <= 1'b0;
            r_open_time     <= 32'd0;
            r_act_time      <= 32'd0;
            r_base          <= INIT_COUNT_RST;
            r_prev          <= INIT_COUNT_RST;
            r_link_lost     <= 1'b0;
            r_loss_pend     <= 1'b0;
            r_wr_ptr        <= '0;
            r_rd_ptr        <= '0;
            r_evq_cnt       <= '0;
        end else begin
            r_in_vld <= i_in_valid && !o_in_stall;
            if (r_in_vld) begin
                r_detecting  <= n_detecting;
                r_open_time  <= n_open_time;
                r_act_time   <= n_act_time;
                r_base       <= n_base;
                r_prev       <= n_prev;
                r_link_lost  <= n_link_lost;
                r_loss_pend  <= n_loss_pend;
            end
            r_wr_ptr  <= r_wr_ptr + EVQ_PTR_W'(push_cnt);
            r_rd_ptr  <= r_rd_ptr + EVQ_PTR_W'(pop);
            r_evq_cnt <= r_evq_cnt + EVQ_CNT_W'(push_cnt) - EVQ_CNT_W'(pop);
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_JUMP_LIMIT:    r_jump_limit    <= i_cfg_data;
                    CFG_QUIET_TIMEOUT: r_quiet_timeout <= i_cfg_data[7:0];
                    CFG_LINK_TIMEOUT:  r_link_timeout  <= i_cfg_data[9:0];
                    CFG_SENSOR_ID:     r_sensor_id     <= i_cfg_data;
                    CFG_INIT_COUNT: begin
                        r_detecting  <= 1'b0;
                        r_open_time  <= 32'd0;
                        r_act_time   <= 32'd0;
                        r_base       <= i_cfg_data;
                        r_prev       <= i_cfg_data;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Payload storage without reset.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_pulse_count <= i_pulse_count;
            r_link_up     <= i_link_up;
            r_now         <= i_now_seconds;
        end
        if (r_in_vld) begin
            r_loss_since <= n_loss_since;
        end
        if (push_cnt != 2'd0) begin
            r_evq[r_wr_ptr] <= slot0;
        end
        if (push_cnt == 2'd2) begin
            r_evq[r_wr_ptr + EVQ_PTR_W'(1)] <= lk_evt;
        end
    end

    assign o_out_valid           = r_evq_cnt != '0;
    assign o_event_kind          = head.kind;
    assign o_event_sensor        = r_sensor_id;
    assign o_event_time          = head.ev_time;
    assign o_crossing_start_time = head.open_time;
    assign o_crossing_last_time  = head.pulse_time;
    assign o_pulses_total        = head.total;
    assign o_base_count          = head.base;
    assign o_final_count         = head.final_cnt;
    assign o_last_of_run         = head.last;

    a_evq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_evq_cnt <= EVQ_CNT_W'(EVQ_DEPTH))
        else $error("event queue count beyond its depth");

    a_evq_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld |-> r_evq_cnt <= EVQ_CNT_W'(EVQ_DEPTH - 2))
        else $error("no room for the events of the sample in flight");

    a_lost_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_link_lost |-> r_loss_pend)
        else $error("link lost without a pending loss");

    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_in_vld)
        else $error("accepted sample not registered");

endmodule
